>>> src/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants for the chiptune voice sequencer.
// ----------------------------------------------------------------------------
package cvs_pkg;

  localparam int unsigned FRAME_CLKS = 70224;
  localparam int unsigned LEN_SHIFT  = 22;      // 4194304 clocks per second
  localparam int unsigned DIV_DW     = 47;      // divider dividend / quotient width
  localparam int unsigned DIV_VW     = 24;      // divider divisor width

  localparam logic [14:0] LFSR_SEED = 15'h7fff;
  localparam logic [2:0]  KIND_TRI   = 3'd3;
  localparam logic [2:0]  KIND_NOISE = 3'd4;
  localparam logic signed [11:0] WAVE_HI = 12'sd1024;
  localparam logic signed [11:0] WAVE_LO = -12'sd1024;
  localparam logic signed [12:0] TRI_TOP = 13'sd3071;
  localparam logic signed [12:0] TRI_MID = 13'sd1024;
  localparam logic [3:0]  VOL_MAX    = 4'd15;
  // x / 12 as (x * 10923) >> 17, exact for x up to 15360
  localparam logic [13:0] RECIP_TWELVE = 14'd10923;
  localparam int unsigned RECIP_SHIFT  = 17;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_SAMPLE  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DSEL_PHASE  = 2'd0,
    DSEL_ENV    = 2'd1
  } dsel_t;

  typedef struct packed {
    logic [15:0] frames;
    logic        rest;
    logic [22:0] freq_q8;
    logic [3:0]  volume;
    logic [1:0]  duty;
    logic [7:0]  envelope;
  } note_t;

  typedef struct packed {
    logic  write;
    logic  restart;
    logic  adv;
    logic  rd;
    logic  mul1;
    logic  len_latch;
    logic  phase_zero;
    logic  div_start;
    dsel_t div_sel;
    logic  take_phase;
    logic  pos;
    logic  zero;
    logic  env_base;
    logic  take_env;
    logic  scale;
    logic  take_div12;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic len_zero;
    logic rest;
    logic no_step;
    logic env_skip;
    logic div_done;
  } stat_t;

  function automatic logic [31:0] duty_edge(input logic [1:0] code);
    logic [31:0] e;
    case (code)
      2'd0:    e = 32'h2000_0000;
      2'd1:    e = 32'h4000_0000;
      2'd2:    e = 32'h8000_0000;
      default: e = 32'hc000_0000;
    endcase
    return e;
  endfunction

endpackage

>>> src/cvs_ram.sv
// ----------------------------------------------------------------------------
// cvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvs_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/cvs_div.sv
// ----------------------------------------------------------------------------
// cvs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvs_div
  import cvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output logic              done,
  output logic [DIV_DW-1:0] quotient
);

  localparam int CW = $clog2(DIV_DW + 1);

  logic [DIV_DW-1:0] dq_r, dq_nxt;
  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dvs_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIV_VW:0]   shifted;
  logic [DIV_VW:0]   diff;

  assign shifted = {rem_r, dq_r[DIV_DW-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(DIV_DW);
    end else if (cnt_r != '0) begin
      if (!diff[DIV_VW]) begin
        rem_nxt = diff[DIV_VW-1:0];
        dq_nxt  = {dq_r[DIV_DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_VW-1:0];
        dq_nxt  = {dq_r[DIV_DW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> src/cvs_ctrl.sv
// ----------------------------------------------------------------------------
// cvs_ctrl
// Sequencing state machine: walks one sample request through the datapath.
// ----------------------------------------------------------------------------
module cvs_ctrl
  import cvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  input  logic       out_free,
  input  stat_t      stat,
  output logic       in_ready,
  output logic       load_out,
  output cmd_t       cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ADV   = 12'b0000_0000_0010,
    S_RD    = 12'b0000_0000_0100,
    S_LEN   = 12'b0000_0000_1000,
    S_MUL   = 12'b0000_0001_0000,
    S_DIVP  = 12'b0000_0010_0000,
    S_POS   = 12'b0000_0100_0000,
    S_ENV   = 12'b0000_1000_0000,
    S_DIVE  = 12'b0001_0000_0000,
    S_SCALE = 12'b0010_0000_0000,
    S_DIV12 = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (req_t'(in_req_type))
            REQ_WRITE:   cmd.write   = 1'b1;
            REQ_RESTART: cmd.restart = 1'b1;
            REQ_SAMPLE:  state_nxt   = S_ADV;
            default:     ;
          endcase
        end
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (stat.stopped) begin
          cmd.zero  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.mul1  = 1'b1;
        state_nxt = stat.len_zero ? S_MUL : S_POS;
      end
      S_MUL: begin
        cmd.len_latch = 1'b1;
        if (stat.no_step) begin
          cmd.phase_zero = 1'b1;
          state_nxt      = S_POS;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_PHASE;
          state_nxt     = S_DIVP;
        end
      end
      S_DIVP: begin
        if (stat.div_done) begin
          cmd.take_phase = 1'b1;
          state_nxt      = S_POS;
        end
      end
      S_POS: begin
        cmd.pos = 1'b1;
        if (stat.rest) begin
          cmd.zero  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ENV;
        end
      end
      S_ENV: begin
        if (stat.env_skip) begin
          cmd.env_base = 1'b1;
          state_nxt    = S_SCALE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_ENV;
          state_nxt     = S_DIVE;
        end
      end
      S_DIVE: begin
        if (stat.div_done) begin
          cmd.take_env = 1'b1;
          state_nxt    = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DIV12;
      end
      S_DIV12: begin
        cmd.take_div12 = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/cvs_dp.sv
// ----------------------------------------------------------------------------
// cvs_dp
// Voice datapath: note store, note timing, phase, waveform, envelope, scaling.
// ----------------------------------------------------------------------------
module cvs_dp
  import cvs_pkg::*;
#(
  parameter int NOTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         voice_kind,
  input  logic [8:0]         note_count,
  input  logic [8:0]         loop_index,
  input  logic [16:0]        sample_rate,
  input  logic [7:0]         in_note_index,
  input  logic [15:0]        in_frames,
  input  logic               in_rest,
  input  logic [22:0]        in_freq_q8,
  input  logic [3:0]         in_volume,
  input  logic [1:0]         in_duty,
  input  logic signed [7:0]  in_envelope,
  output logic signed [11:0] sample
);

  localparam int AW   = $clog2(NOTE_DEPTH);
  localparam int CW0  = $clog2(NOTE_DEPTH + 1);
  localparam int CNTW = (CW0 > 9) ? CW0 : 9;

  // voice state
  logic [8:0]  cur_r;
  logic [31:0] pos_r, pos_old_r, len_r, step_r, phase_r;
  logic [21:0] frac_r;
  logic [14:0] lfsr_r;
  logic        stopped_r;
  logic [32:0] mul1_r;
  logic [23:0] denom_r;
  logic signed [11:0] wave_r, sample_r;
  logic [3:0]  vol_r;
  logic        neg_r;
  logic [13:0] mag_r;

  // note store
  note_t       wentry, note;
  logic [53:0] rdata;
  logic        we;

  assign we     = cmd.write && (32'(in_note_index) < NOTE_DEPTH);
  assign wentry = '{frames: in_frames, rest: in_rest, freq_q8: in_freq_q8,
                    volume: in_volume, duty: in_duty, envelope: in_envelope};
  assign note   = note_t'(rdata);

  cvs_ram #(.WIDTH(54), .DEPTH(NOTE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(in_note_index)),
    .wdata (wentry),
    .re    (cmd.rd),
    .raddr (AW'(cur_r)),
    .rdata (rdata)
  );

  // note advance and loop
  logic [CNTW-1:0] count;
  logic [8:0]      cur_a;
  logic [31:0]     pos_a, len_a;
  logic            at_end;

  always_comb begin
    count = (CNTW'(note_count) > CNTW'(NOTE_DEPTH)) ? CNTW'(NOTE_DEPTH)
                                                     : CNTW'(note_count);
    cur_a = cur_r;
    pos_a = pos_r;
    len_a = len_r;
    if (len_r != '0 && pos_r >= len_r) begin
      cur_a = cur_r + 9'd1;
      pos_a = '0;
      len_a = '0;
    end
    at_end = 1'b0;
    if (CNTW'(cur_a) >= count) begin
      if (CNTW'(loop_index) >= count) begin
        at_end = 1'b1;
      end else begin
        cur_a = loop_index;
      end
    end
  end

  // note length: frames * 70224 * rate + carried fraction
  logic [50:0] total;
  assign total = 51'(mul1_r * sample_rate) + 51'(frac_r);

  // shared divider
  logic [DIV_DW-1:0] div_a, div_q;
  logic [DIV_VW-1:0] div_b;
  logic              div_done;
  logic signed [16:0] prod;
  logic [16:0]        prod_mag;
  logic [27:0]        recip;
  logic [11:0]        q12;

  assign prod     = wave_r * $signed({1'b0, vol_r});
  assign prod_mag = prod[16] ? 17'(-prod) : 17'(prod);
  assign recip    = mag_r * RECIP_TWELVE;
  assign q12      = {1'b0, recip[27:RECIP_SHIFT]};

  always_comb begin
    case (cmd.div_sel)
      DSEL_PHASE: begin
        div_a = {note.freq_q8, 24'd0};
        div_b = DIV_VW'(sample_rate);
      end
      default: begin
        div_a = DIV_DW'({pos_old_r, 6'd0});
        div_b = denom_r;
      end
    endcase
  end

  cvs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // phase, waveform
  logic [31:0] phase_a;
  logic        wrap;
  logic [14:0] lfsr_a;
  logic [10:0] tx;
  logic signed [12:0] tri_w;
  logic signed [11:0] wave_a;
  logic [7:0]  period;
  logic [24:0] denom_a;

  always_comb begin
    phase_a = phase_r + step_r;
    wrap    = phase_a < phase_r;
    lfsr_a  = lfsr_r;
    if (voice_kind == KIND_NOISE && wrap) begin
      lfsr_a = {lfsr_r[0] ^ lfsr_r[1], lfsr_r[14:1]};
    end
    tx    = phase_a[31:21];
    tri_w = tx[10] ? TRI_TOP - $signed({1'b0, tx, 1'b0})
                   : $signed({1'b0, tx, 1'b0}) - TRI_MID;
    if (voice_kind == KIND_NOISE) begin
      wave_a = lfsr_a[0] ? WAVE_HI : WAVE_LO;
    end else if (voice_kind == KIND_TRI) begin
      wave_a = tri_w[11:0];
    end else begin
      wave_a = (phase_a < duty_edge(note.duty)) ? WAVE_HI : WAVE_LO;
    end
    period  = note.envelope[7] ? 8'(-note.envelope) : note.envelope;
    denom_a = sample_rate * period;
  end

  // volume
  logic [3:0] base_vol, env_vol;
  logic [4:0] csat;
  logic [5:0] raised;

  always_comb begin
    if (voice_kind == KIND_TRI) begin
      case (note.volume)
        4'd1:    base_vol = 4'd12;
        4'd2:    base_vol = 4'd6;
        4'd3:    base_vol = 4'd3;
        default: base_vol = 4'd0;
      endcase
    end else begin
      base_vol = note.volume;
    end
    csat   = (|div_q[DIV_DW-1:4]) ? 5'd16 : {1'b0, div_q[3:0]};
    raised = {2'b0, base_vol} + {1'b0, csat};
    if (note.envelope[7]) begin
      env_vol = (raised > 6'(VOL_MAX)) ? VOL_MAX : raised[3:0];
    end else begin
      env_vol = ({1'b0, base_vol} < csat) ? 4'd0 : 4'(5'(base_vol) - csat);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      cur_r     <= '0;
      pos_r     <= '0;
      len_r     <= '0;
      frac_r    <= '0;
      step_r    <= '0;
      phase_r   <= '0;
      lfsr_r    <= LFSR_SEED;
      stopped_r <= 1'b0;
    end else begin
      if (cmd.adv) begin
        cur_r     <= cur_a;
        pos_r     <= pos_a;
        len_r     <= len_a;
        stopped_r <= at_end;
      end
      if (cmd.len_latch) begin
        len_r  <= 32'(total[50:LEN_SHIFT]);
        frac_r <= total[LEN_SHIFT-1:0];
      end
      if (cmd.phase_zero) begin
        step_r <= '0;
      end
      if (cmd.take_phase) begin
        step_r <= div_q[31:0];
      end
      if (cmd.pos) begin
        pos_r <= pos_r + 32'd1;
        if (!note.rest) begin
          phase_r <= phase_a;
          lfsr_r  <= lfsr_a;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      mul1_r <= 33'(note.frames * 17'(FRAME_CLKS));
    end
    if (cmd.pos) begin
      pos_old_r <= pos_r;
      wave_r    <= wave_a;
      denom_r   <= denom_a[23:0];
    end
    if (cmd.env_base) begin
      vol_r <= base_vol;
    end
    if (cmd.take_env) begin
      vol_r <= env_vol;
    end
    if (cmd.scale) begin
      mag_r <= prod_mag[13:0];
      neg_r <= prod[16];
    end
    if (cmd.zero) begin
      sample_r <= '0;
    end
    if (cmd.take_div12) begin
      sample_r <= neg_r ? -q12 : q12;
    end
  end

  assign stat.stopped  = stopped_r;
  assign stat.len_zero = (len_r == '0);
  assign stat.rest     = note.rest;
  assign stat.no_step  = note.rest || (sample_rate == '0);
  assign stat.env_skip = (voice_kind == KIND_TRI) || (note.envelope == '0) ||
                         (denom_r == '0);
  assign stat.div_done = div_done;
  assign sample        = sample_r;

endmodule

>>> src/chiptune_voice_sequencer_top.sv
// ----------------------------------------------------------------------------
// chiptune_voice_sequencer_top
// One synthesizer voice playing a stored note list, with APB register port.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_ready  | req_type, note_index, frames, rest,
//           |           |                    | freq_q8, volume, duty, envelope
//  out_     | output    | out_valid/out_ready| sample
//  cfg_     | input     | APB psel/penable   | voice_kind, note_count, loop_index,
//           |           |                    | sample_rate at 0x0/0x4/0x8/0xc
//
// Write, restart and ignored requests leave the block idle and ready.
// A sample request runs the shared 47-step divider up to twice (phase
// step on a new note, envelope); the scale by twelve is a reciprocal
// multiply. A stopped voice skips straight to a zero sample.
// rst_n is synchronous; the note store is not cleared.
// A finished sample waits in the output register; the next request is
// taken meanwhile and only its final load waits for out_ready.
// ----------------------------------------------------------------------------
module chiptune_voice_sequencer_top
  import cvs_pkg::*;
#(
  parameter int NOTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_note_index,
  input  logic [15:0]        in_frames,
  input  logic               in_rest,
  input  logic [22:0]        in_freq_q8,
  input  logic [3:0]         in_volume,
  input  logic [1:0]         in_duty,
  input  logic signed [7:0]  in_envelope,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] out_sample,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [1:0] {
    REG_KIND  = 2'd0,
    REG_COUNT = 2'd1,
    REG_LOOP  = 2'd2,
    REG_RATE  = 2'd3
  } reg_t;

  logic [2:0]  kind_r;
  logic [8:0]  count_r, loop_r;
  logic [16:0] rate_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= 3'd1;
      count_r <= 9'd0;
      loop_r  <= 9'd256;
      rate_r  <= 17'd44100;
    end else if (wr) begin
      case (reg_t'(cfg_paddr[3:2]))
        REG_KIND:  kind_r  <= cfg_pwdata[2:0];
        REG_COUNT: count_r <= cfg_pwdata[8:0];
        REG_LOOP:  loop_r  <= cfg_pwdata[8:0];
        default:   rate_r  <= cfg_pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    case (reg_t'(cfg_paddr[3:2]))
      REG_KIND:  cfg_prdata = 32'(kind_r);
      REG_COUNT: cfg_prdata = 32'(count_r);
      REG_LOOP:  cfg_prdata = 32'(loop_r);
      default:   cfg_prdata = 32'(rate_r);
    endcase
  end

  cmd_t  cmd;
  stat_t stat;
  logic  load_out, out_free;
  logic  out_valid_r;
  logic signed [11:0] out_sample_r, dp_sample;

  assign out_free = !out_valid_r || out_ready;

  cvs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .out_free    (out_free),
    .stat        (stat),
    .in_ready    (in_ready),
    .load_out    (load_out),
    .cmd         (cmd)
  );

  cvs_dp #(.NOTE_DEPTH(NOTE_DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .voice_kind    (kind_r),
    .note_count    (count_r),
    .loop_index    (loop_r),
    .sample_rate   (rate_r),
    .in_note_index (in_note_index),
    .in_frames     (in_frames),
    .in_rest       (in_rest),
    .in_freq_q8    (in_freq_q8),
    .in_volume     (in_volume),
    .in_duty       (in_duty),
    .in_envelope   (in_envelope),
    .sample        (dp_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= dp_sample;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // once a sample request is taken, the block leaves idle and in_ready drops
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_SAMPLE) |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // a result is never loaded over one that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // a new result appears only after a load
  a_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load_out))
    else $error("result without a load");

endmodule
